// ===== hdl/timestamp_ordered_event_queue_unit_assert.svh =====
// Assertion macros shared by the event queue checker.
`ifndef TIMESTAMP_ORDERED_EVENT_QUEUE_UNIT_ASSERT_SVH
`define TIMESTAMP_ORDERED_EVENT_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define TOEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event queue check failed");

// Next-cycle implication, quiet while reset is held.
`define TOEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event queue check failed");

`endif

// ===== hdl/toeq_pkg.sv =====
// Shared constants and types of the timestamp-ordered event queue.
package toeq_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TIME_W      = 48;
  localparam int TAG_W       = 16;
  localparam int DELAY_W     = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FIRED = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_FIRE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [TIME_W-1:0] ts;
    logic [TAG_W-1:0]  tag;
  } cell_ctl_t;

endpackage

// ===== hdl/timestamp_ordered_event_queue_unit.sv =====
// Timestamp-ordered discrete-event queue, top level.
//
// Keeps up to DEPTH pending events sorted by absolute timestamp in a chain of
// cells. An add word (kind 0) turns its delay into an absolute timestamp,
// current time plus delay saturated at 2^48-1, and slots the event in behind
// every entry due at the same time or earlier, so equal timestamps fire in
// arrival order; the result word carries status added, or queue full when all
// DEPTH cells hold events (the event is then dropped). An advance word (kind 1)
// moves the current time to the earliest timestamp and fires the entries due
// then, oldest first, up to MAX_RESULTS per advance, with last set on the
// final one; an empty queue returns one queue empty word carrying the current
// time. An add, a dropped add and an empty advance each return one result
// word; an advance that fires n events returns n words, one per fired event,
// the chain shifting by one cell as each head leaves. Results pass
// through a single output register; the next input word is taken as soon as
// the last result of the previous one has moved into it and the register is
// free or being drained in the same cycle.
module timestamp_ordered_event_queue_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [toeq_pkg::DELAY_W-1:0] in_delay,
  input  logic [toeq_pkg::TAG_W-1:0]   in_event_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [toeq_pkg::TAG_W-1:0]   out_fired_id,
  output logic [toeq_pkg::TIME_W-1:0]  out_fire_time,
  output logic                         out_last
);
  import toeq_pkg::*;

  // Control state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FIRE_W-1:0] fired_r, fired_nxt;
  logic [TIME_W-1:0] cur_time_r, cur_time_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Output word register.
  status_t           out_status_r, out_status_nxt;
  logic [TAG_W-1:0]  out_id_r, out_id_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;
  logic              out_last_r, out_last_nxt;

  // Chain wiring.
  cell_ctl_t         ctl;
  entry_t            ent   [DEPTH];
  logic              le    [DEPTH];
  logic              in_use[DEPTH];

  logic              out_free;
  logic              in_acc;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] ts;
  logic              full;
  logic              head_same;

  // The output register can take a word when empty or drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Absolute timestamp, clamped at the top of the time range.
  assign sum  = {1'b0, cur_time_r} + (TIME_W+1)'(in_delay);
  assign ts   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign full = (count_r == CNT_W'(DEPTH));

  // Does the entry behind the head share its timestamp?
  assign head_same = (count_r >= CNT_W'(2)) && (ent[1].tstamp == ent[0].tstamp);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_ent;
      entry_t right_ent;
      logic   le_prev;

      assign in_use[gi] = (count_r > CNT_W'(gi));

      if (gi == 0) begin : g_head
        assign left_ent = '0;
        assign le_prev  = 1'b1;
      end else begin : g_body
        assign left_ent = ent[gi-1];
        assign le_prev  = le[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_ent = '0;
      end else begin : g_inner
        assign right_ent = ent[gi+1];
      end

      toeq_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .in_use   (in_use[gi]),
        .le_prev  (le_prev),
        .left_ent (left_ent),
        .right_ent(right_ent),
        .ent      (ent[gi]),
        .le       (le[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    fired_nxt      = fired_r;
    cur_time_nxt   = cur_time_r;
    // Drop the held word once taken.
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_time_nxt   = out_time_r;
    out_last_nxt   = out_last_r;
    ctl.ins        = 1'b0;
    ctl.pop        = 1'b0;
    ctl.ts         = ts;
    ctl.tag        = in_event_id;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          out_last_nxt  = 1'b1;
          if (in_kind == KIND_ADD) begin
            out_time_nxt = ts;
            if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_ADDED;
              ctl.ins        = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            out_status_nxt = ST_EMPTY;
            out_time_nxt   = cur_time_r;
          end else begin
            // Move time to the head and fire it straight away.
            cur_time_nxt   = ent[0].tstamp;
            out_status_nxt = ST_FIRED;
            out_id_nxt     = ent[0].tag;
            out_time_nxt   = ent[0].tstamp;
            ctl.pop        = 1'b1;
            count_nxt      = count_r - CNT_W'(1);
            fired_nxt      = FIRE_W'(1);
            out_last_nxt   = !head_same || (fired_nxt == FIRE_W'(MAX_RESULTS));
            if (!out_last_nxt) begin
              state_nxt = S_FIRE;
            end
          end
        end
      end
      S_FIRE: begin
        // Fire the next entry that shares the head time, one per cycle while the output register is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FIRED;
          out_id_nxt     = ent[0].tag;
          out_time_nxt   = ent[0].tstamp;
          ctl.pop        = 1'b1;
          count_nxt      = count_r - CNT_W'(1);
          fired_nxt      = fired_r + FIRE_W'(1);
          out_last_nxt   = !head_same || (fired_nxt == FIRE_W'(MAX_RESULTS));
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fired_r     <= '0;
      cur_time_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fired_r     <= fired_nxt;
      cur_time_r  <= cur_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_time_r   <= out_time_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_fired_id  = out_id_r;
  assign out_fire_time = out_time_r;
  assign out_last      = out_last_r;

endmodule

// ===== hdl/toeq_cell.sv =====
// One slot of the sorted event chain.
module toeq_cell (
  input  logic               clk,
  input  toeq_pkg::cell_ctl_t ctl,
  input  logic               in_use,
  input  logic               le_prev,
  input  toeq_pkg::entry_t   left_ent,
  input  toeq_pkg::entry_t   right_ent,
  output toeq_pkg::entry_t   ent,
  output logic               le
);
  import toeq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // Occupied and due no later than the new event: stays put on insert.
  assign le  = in_use && (ent_r.tstamp <= ctl.ts);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    priority if (ctl.ins) begin
      priority if (le) begin
        ent_nxt = ent_r;
      end else if (le_prev) begin
        ent_nxt.tstamp = ctl.ts;
        ent_nxt.tag    = ctl.tag;
      end else begin
        ent_nxt = left_ent;
      end
    end else if (ctl.pop) begin
      ent_nxt = right_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== hdl/toeq_checker.sv =====
// Port-level checks of the event queue, bound to the top level.
`include "timestamp_ordered_event_queue_unit_assert.svh"

module toeq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   out_status,
  input logic [toeq_pkg::TAG_W-1:0]   out_fired_id,
  input logic [toeq_pkg::TIME_W-1:0]  out_fire_time,
  input logic                         out_last
);
  import toeq_pkg::*;

  logic [TAG_W+TIME_W+2:0] out_word;

  assign out_word = {out_status, out_fired_id, out_fire_time, out_last};

  // A stalled result word holds.
  `TOEQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // Only fired words can be followed by more words of the same item.
  `TOEQ_ASSERT_NOW(a_single_last, out_valid && (out_status != ST_FIRED), out_last)

  // Tag is zero unless an event fired.
  `TOEQ_ASSERT_NOW(a_id_zero, out_valid && (out_status != ST_FIRED), out_fired_id == '0)

  // No new item while a burst of fired events is still running.
  `TOEQ_ASSERT_NOW(a_burst_block, out_valid && (out_status == ST_FIRED) && !out_last, in_stall)

endmodule

bind timestamp_ordered_event_queue_unit toeq_checker u_toeq_checker (.*);

// ===== sim/event_queue_checker.sv =====
// Checker for the event queue: predicts every result word and compares it with the block.
`timescale 1ns / 100ps

module event_queue_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_kind,
  input  logic [toeq_pkg::DELAY_W-1:0] in_delay,
  input  logic [toeq_pkg::TAG_W-1:0]   in_event_id,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [1:0]                   out_status,
  input  logic [toeq_pkg::TAG_W-1:0]   out_fired_id,
  input  logic [toeq_pkg::TIME_W-1:0]  out_fire_time,
  input  logic                         out_last,
  output int                           fail_count = 0,
  output int                           pending = 0
);
  import toeq_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] tstamp;
    logic              last;
  } result_word_t;

  // Pending events, earliest first; equal timestamps in arrival order.
  entry_t            event_list[$];
  result_word_t      due_words[$];
  logic [TIME_W-1:0] now_time = '0;
  int                errors = 0;

  task automatic push_word(input status_t st, input logic [TAG_W-1:0] tag,
                           input logic [TIME_W-1:0] ts, input logic lst);
    result_word_t w;
    w.status = st;
    w.tag    = tag;
    w.tstamp = ts;
    w.last   = lst;
    due_words.insert(due_words.size(), w);
  endtask

  task automatic schedule_events(input logic kind, input logic [DELAY_W-1:0] delay,
                                 input logic [TAG_W-1:0] id);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] ts;
    int                pos;
    int                n;
    entry_t            e;
    if (kind == KIND_ADD) begin
      // Saturate the absolute timestamp at the top of the range.
      sum = {1'b0, now_time} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
      ts  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      if (event_list.size() >= DEPTH) begin
        push_word(ST_FULL, '0, ts, 1'b1);
      end else begin
        pos = 0;
        while (pos < event_list.size() && event_list[pos].tstamp <= ts) pos++;
        e.tstamp = ts;
        e.tag    = id;
        event_list.insert(pos, e);
        push_word(ST_ADDED, '0, ts, 1'b1);
      end
    end else if (event_list.size() == 0) begin
      push_word(ST_EMPTY, '0, now_time, 1'b1);
    end else begin
      now_time = event_list[0].tstamp;
      n = 0;
      while (n < event_list.size() && n < MAX_RESULTS && event_list[n].tstamp == now_time)
        n++;
      for (int i = 0; i < n; i++) begin
        e = event_list.pop_front();
        push_word(ST_FIRED, e.tag, e.tstamp, (i == n - 1));
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    errors++;
    $display("%0t %s: expected %h, actual %h", $time, what, want, got);
  endtask

  task automatic check_word();
    result_word_t w;
    if (due_words.size() == 0) begin
      report("result word with none pending", '0, 64'(out_fire_time));
    end else begin
      w = due_words.pop_front();
      if (out_status !== w.status) report("status", 64'(w.status), 64'(out_status));
      if (out_fired_id !== w.tag) report("fired_id", 64'(w.tag), 64'(out_fired_id));
      if (out_fire_time !== w.tstamp) report("fire_time", 64'(w.tstamp), 64'(out_fire_time));
      if (out_last !== w.last) report("last", 64'(w.last), 64'(out_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      event_list.delete();
      due_words.delete();
      now_time = '0;
    end else begin
      if (in_valid && !in_stall) schedule_events(in_kind, in_delay, in_event_id);
      if (out_valid && !out_stall) check_word();
    end
    fail_count <= errors;
    pending    <= due_words.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the event queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import toeq_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = KIND_ADD;
  logic [DELAY_W-1:0] in_delay = '0;
  logic [TAG_W-1:0]   in_event_id = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [TAG_W-1:0]   out_fired_id;
  logic [TIME_W-1:0]  out_fire_time;
  logic               out_last;

  int                 fail_count;
  int                 pending;

  // Sender and receiver pacing.
  int                 burst_left = 0;
  int                 stall_mode = 0;
  int                 stall_run = 0;

  int                 items_sent = 0;
  int                 random_items = 0;

  timestamp_ordered_event_queue_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_delay     (in_delay),
    .in_event_id  (in_event_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_fired_id (out_fired_id),
    .out_fire_time(out_fire_time),
    .out_last     (out_last)
  );

  event_queue_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_delay     (in_delay),
    .in_event_id  (in_event_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_fired_id (out_fired_id),
    .out_fire_time(out_fire_time),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: pick a stall flavour for a run of cycles, then pick again.
  // Flavours: never stall, light random, heavy random, long blocks of stall.
  always @(posedge clk) begin : stall_gen
    logic stall_next;
    case (stall_mode)
      0:       stall_next = 1'b0;
      1:       stall_next = ($urandom_range(0, 3) == 0);
      2:       stall_next = ($urandom_range(0, 1) == 0);
      default: stall_next = ((stall_run % 16) < 12);
    endcase
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(8, 64);
    end else begin
      stall_run <= stall_run - 1;
    end
    out_stall <= stall_next;
  end

  // Offer one word and hold it until accepted. Called and returns at a rising
  // edge. Bursts of random length alternate with random gaps. The stall is
  // sampled on the falling edge, where it already holds its value for the next
  // rising edge.
  task automatic send_word(input logic kind, input logic [DELAY_W-1:0] delay,
                           input logic [TAG_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_delay    <= delay;
    in_event_id <= id;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Mostly small delays so equal timestamps are common; now and then a wide
  // random delay or one of the two extremes.
  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick_delay = $urandom_range(0, 3);
      4, 5, 6:    pick_delay = $urandom_range(0, 255);
      7, 8:       pick_delay = $urandom();
      default:    pick_delay = $urandom_range(0, 1) ? {DELAY_W{1'b1}} : '0;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    rand_tag = TAG_W'($urandom_range(0, 65535));
  endfunction

  initial begin : stimulus
    int add_pct;

    // Hold reset at the start, then release it.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: advance on an empty queue at time zero.
    send_word(KIND_ADVANCE, '0, '0);
    // Extremes of delay and tag, and two events due at the same time.
    send_word(KIND_ADD, '0, 16'h0000);
    send_word(KIND_ADD, {DELAY_W{1'b1}}, 16'hFFFF);
    send_word(KIND_ADD, '0, 16'h1234);
    send_word(KIND_ADD, 32'd7, 16'hA5A5);
    // Fire the pair at time zero in arrival order, then the rest one by one.
    send_word(KIND_ADVANCE, $urandom(), rand_tag());
    send_word(KIND_ADVANCE, $urandom(), rand_tag());
    send_word(KIND_ADVANCE, $urandom(), rand_tag());
    // Empty again, now with a non-zero current time.
    send_word(KIND_ADVANCE, $urandom(), rand_tag());
    // Fill every slot with one timestamp, overflow once, then fire them all.
    repeat (DEPTH) send_word(KIND_ADD, 32'd3, rand_tag());
    send_word(KIND_ADD, 32'd1, rand_tag());
    send_word(KIND_ADVANCE, '0, '0);
    send_word(KIND_ADVANCE, '0, '0);

    // Random: segments with their own add/advance mix, so the queue swings
    // between empty, part full and overflowing.
    repeat (11) begin
      add_pct = $urandom_range(25, 90);
      repeat (40) begin
        send_word(($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_ADVANCE,
                  pick_delay(), rand_tag());
        random_items++;
      end
    end

    // Drain whatever is left; each advance removes at least one event.
    repeat (DEPTH + 1) send_word(KIND_ADVANCE, $urandom(), rand_tag());

    // Let the last words drain, then allow a few spare cycles for strays.
    wait_idle();
    repeat (20) @(posedge clk);

    $display("Ran %0d input words: directed edges, %0d random mixed adds and advances,",
             items_sent, random_items);
    $display("then a full drain; %0d mismatches seen", fail_count);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/toeq_pkg.sv
hdl/toeq_cell.sv
hdl/timestamp_ordered_event_queue_unit.sv
hdl/toeq_checker.sv
sim/event_queue_checker.sv
sim/testbench.sv
